FILE: hw/rtl/hse_pkg.sv
// Package: types, constants and the microcode table of the heap sort engine.
`default_nettype none

package hse_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int AW        = $clog2(MAX_ITEMS);   // store address
	localparam int CW        = $clog2(MAX_ITEMS + 1); // element count
	localparam int DW        = 32;

	typedef struct packed {
		logic signed [DW-1:0] value;
		logic                 last;
	} hse_in_t;

	typedef struct packed {
		logic signed [DW-1:0] sorted_value;
		logic                 last_result;
		logic                 overflow;
	} hse_out_t;

	// microcode program addresses
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_START,
		ST_BLOOP,
		ST_BRD,
		ST_BNV,
		ST_S0,
		ST_S1,
		ST_S2,
		ST_S3,
		ST_EXIT,
		ST_RET,
		ST_RET2,
		ST_SINIT,
		ST_SLOOP,
		ST_SA,
		ST_SB,
		ST_OUT0,
		ST_OUT1,
		ST_FIN
	} step_t;

	typedef enum logic [3:0] {
		C_NONE,
		C_ALWAYS,
		C_NOT_LAST,
		C_I_ZERO,
		C_L_GE_N,
		C_MOVED,
		C_BUILD,
		C_N_LE_1,
		C_OUT_FULL,
		C_MORE
	} cond_t;

	typedef enum logic [2:0] {RA_I, RA_L, RA_R, RA_ZERO, RA_NM1} ra_t;
	typedef enum logic [1:0] {WA_NODE, WA_NM1, WA_CNT} wa_t;
	typedef enum logic [1:0] {WD_BV, WD_NV, WD_RDATA, WD_IN} wd_t;
	typedef enum logic [1:0] {IOP_HOLD, IOP_DEC, IOP_INC, IOP_CLR} iop_t;
	typedef enum logic [1:0] {NOP_HOLD, NOP_FROM_I, NOP_ZERO, NOP_FROM_BIG} nop_t;
	typedef enum logic [1:0] {PICK_NONE, PICK_LEFT, PICK_RIGHT} pick_t;

	// one control word
	typedef struct packed {
		cond_t cond;
		step_t target;
		logic  in_rdy;
		ra_t   ra;
		logic  we;
		wa_t   wa;
		wd_t   wd;
		logic  start;
		iop_t  iop;
		nop_t  nop;
		logic  nv_ld;
		pick_t pick;
		logic  n_dec;
		logic  phase_sort;
		logic  out_ld;
		logic  fin;
	} hse_ctrl_t;

	// datapath flags seen by the jump logic
	typedef struct packed {
		logic in_last_fire;
		logic i_zero;
		logic l_ge_n;
		logic moved;
		logic build;
		logic n_le_1;
		logic out_full;
		logic more;
	} hse_stat_t;

	// read-only control store
	function automatic hse_ctrl_t ucode(step_t s);
		hse_ctrl_t c;
		c = hse_ctrl_t'('0);
		unique case (s)
			ST_IDLE: begin
				c.in_rdy = 1'b1;
				c.we     = 1'b1;
				c.wa     = WA_CNT;
				c.wd     = WD_IN;
				c.cond   = C_NOT_LAST;
				c.target = ST_IDLE;
			end
			ST_START: begin
				c.start = 1'b1;
			end
			ST_BLOOP: begin
				c.iop    = IOP_DEC;
				c.cond   = C_I_ZERO;
				c.target = ST_SINIT;
			end
			ST_BRD: begin
				c.ra  = RA_I;
				c.nop = NOP_FROM_I;
			end
			ST_BNV: begin
				c.nv_ld  = 1'b1;
				c.cond   = C_ALWAYS;
				c.target = ST_S0;
			end
			ST_S0: begin
				c.ra     = RA_L;
				c.cond   = C_L_GE_N;
				c.target = ST_EXIT;
			end
			ST_S1: begin
				c.ra   = RA_R;
				c.pick = PICK_LEFT;
			end
			ST_S2: begin
				c.pick = PICK_RIGHT;
			end
			ST_S3: begin
				c.we     = 1'b1;
				c.wa     = WA_NODE;
				c.wd     = WD_BV;
				c.nop    = NOP_FROM_BIG;
				c.cond   = C_MOVED;
				c.target = ST_S0;
			end
			ST_EXIT: begin
				c.we = 1'b1;
				c.wa = WA_NODE;
				c.wd = WD_NV;
			end
			ST_RET: begin
				c.cond   = C_BUILD;
				c.target = ST_BLOOP;
			end
			ST_RET2: begin
				c.cond   = C_ALWAYS;
				c.target = ST_SLOOP;
			end
			ST_SINIT: begin
				c.iop        = IOP_CLR;
				c.phase_sort = 1'b1;
			end
			ST_SLOOP: begin
				c.ra     = RA_ZERO;
				c.cond   = C_N_LE_1;
				c.target = ST_OUT0;
			end
			ST_SA: begin
				c.ra    = RA_NM1;
				c.we    = 1'b1;
				c.wa    = WA_NM1;
				c.wd    = WD_RDATA;
				c.n_dec = 1'b1;
			end
			ST_SB: begin
				c.nv_ld  = 1'b1;
				c.nop    = NOP_ZERO;
				c.cond   = C_ALWAYS;
				c.target = ST_S0;
			end
			ST_OUT0: begin
				c.ra     = RA_I;
				c.cond   = C_OUT_FULL;
				c.target = ST_OUT0;
			end
			ST_OUT1: begin
				c.out_ld = 1'b1;
				c.iop    = IOP_INC;
				c.cond   = C_MORE;
				c.target = ST_OUT0;
			end
			ST_FIN: begin
				c.fin    = 1'b1;
				c.cond   = C_ALWAYS;
				c.target = ST_IDLE;
			end
			default: begin
				c.cond   = C_ALWAYS;
				c.target = ST_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/hse_sequencer.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`default_nettype none

module hse_sequencer (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire hse_pkg::hse_stat_t stat,
	output hse_pkg::hse_ctrl_t     ctrl
);
	import hse_pkg::*;

	step_t step_q;
	step_t step_d;
	logic  take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	always_comb begin
		ctrl = ucode(step_q);
		unique case (ctrl.cond)
			C_NONE:     take = 1'b0;
			C_ALWAYS:   take = 1'b1;
			C_NOT_LAST: take = !stat.in_last_fire;
			C_I_ZERO:   take = stat.i_zero;
			C_L_GE_N:   take = stat.l_ge_n;
			C_MOVED:    take = stat.moved;
			C_BUILD:    take = stat.build;
			C_N_LE_1:   take = stat.n_le_1;
			C_OUT_FULL: take = stat.out_full;
			C_MORE:     take = stat.more;
			default:    take = 1'b0;
		endcase
		step_d = take ? ctrl.target : step_t'(step_q + 5'd1);
	end

endmodule

`default_nettype wire

FILE: hw/rtl/hse_datapath.sv
// Datapath: element store, heap index registers, compare unit and output register.
`default_nettype none

module hse_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire hse_pkg::hse_ctrl_t ctrl,
	output hse_pkg::hse_stat_t      stat,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire hse_pkg::hse_in_t   in_word,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output hse_pkg::hse_out_t       out_word
);
	import hse_pkg::*;

	logic [DW-1:0] mem [MAX_ITEMS];
	logic [DW-1:0] rdata_q;

	logic [CW-1:0] cnt_q;
	logic          drop_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] i_q;
	logic [AW-1:0] node_q;
	logic [AW-1:0] big_q;
	logic [DW-1:0] nv_q;
	logic [DW-1:0] bv_q;
	logic          sort_q;
	logic          ovld_q;
	hse_out_t      oword_q;

	logic          fire;
	logic          full;
	logic [CW-1:0] lidx;
	logic [CW:0]   ridx;
	logic [CW-1:0] nm1;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	logic [DW-1:0] wdata;
	logic          wen;
	logic          more;

	assign in_ready = ctrl.in_rdy;
	assign fire     = in_valid && ctrl.in_rdy;
	assign full     = (cnt_q == CW'(MAX_ITEMS));
	assign lidx     = {node_q, 1'b1};
	assign ridx     = {1'b0, node_q, 1'b0} + (CW+1)'(2);
	assign nm1      = n_q - CW'(1);
	assign more     = ({1'b0, i_q} + (CW+1)'(1)) < {1'b0, cnt_q};

	always_comb begin
		case (ctrl.ra)
			RA_I:    raddr = i_q[AW-1:0];
			RA_L:    raddr = lidx[AW-1:0];
			RA_R:    raddr = ridx[AW-1:0];
			RA_NM1:  raddr = nm1[AW-1:0];
			default: raddr = '0;
		endcase
		case (ctrl.wa)
			WA_NODE: waddr = node_q;
			WA_NM1:  waddr = nm1[AW-1:0];
			default: waddr = cnt_q[AW-1:0];
		endcase
		case (ctrl.wd)
			WD_BV:    wdata = bv_q;
			WD_NV:    wdata = nv_q;
			WD_RDATA: wdata = rdata_q;
			default:  wdata = in_word.value;
		endcase
		// input writes only land for an accepted word with room left
		wen = ctrl.we && ((ctrl.wd != WD_IN) || (fire && !full));
	end

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			drop_q <= 1'b0;
			n_q    <= '0;
			i_q    <= '0;
			node_q <= '0;
			big_q  <= '0;
			sort_q <= 1'b0;
			ovld_q <= 1'b0;
		end else begin
			if (fire) begin
				if (full) begin
					drop_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
			if (ctrl.start) begin
				n_q    <= cnt_q;
				i_q    <= cnt_q >> 1;
				sort_q <= 1'b0;
			end else begin
				case (ctrl.iop)
					IOP_DEC: i_q <= i_q - CW'(1);
					IOP_INC: i_q <= i_q + CW'(1);
					IOP_CLR: i_q <= '0;
					default: i_q <= i_q;
				endcase
			end
			if (ctrl.n_dec) begin
				n_q <= nm1;
			end
			if (ctrl.phase_sort) begin
				sort_q <= 1'b1;
			end
			case (ctrl.nop)
				NOP_FROM_I:   node_q <= i_q[AW-1:0];
				NOP_ZERO:     node_q <= '0;
				NOP_FROM_BIG: node_q <= big_q;
				default:      node_q <= node_q;
			endcase
			case (ctrl.pick)
				PICK_LEFT: begin
					big_q <= ($signed(rdata_q) > $signed(nv_q)) ? lidx[AW-1:0] : node_q;
				end
				PICK_RIGHT: begin
					if ((ridx < {1'b0, n_q}) && ($signed(rdata_q) > $signed(bv_q))) begin
						big_q <= ridx[AW-1:0];
					end
				end
				default: big_q <= big_q;
			endcase
			if (ctrl.fin) begin
				cnt_q  <= '0;
				drop_q <= 1'b0;
			end
			if (ctrl.out_ld) begin
				ovld_q <= 1'b1;
			end else if (out_ready) begin
				ovld_q <= 1'b0;
			end
		end
	end

	// value registers, no reset needed
	always_ff @(posedge clk) begin
		if (ctrl.nv_ld) begin
			nv_q <= rdata_q;
		end
		case (ctrl.pick)
			PICK_LEFT: begin
				bv_q <= ($signed(rdata_q) > $signed(nv_q)) ? rdata_q : nv_q;
			end
			PICK_RIGHT: begin
				if ((ridx < {1'b0, n_q}) && ($signed(rdata_q) > $signed(bv_q))) begin
					bv_q <= rdata_q;
				end
			end
			default: bv_q <= bv_q;
		endcase
		if (ctrl.out_ld) begin
			oword_q.sorted_value <= $signed(rdata_q);
			oword_q.last_result  <= !more;
			oword_q.overflow     <= drop_q;
		end
	end

	assign out_valid = ovld_q;
	assign out_word  = oword_q;

	always_comb begin
		stat.in_last_fire = fire && in_word.last;
		stat.i_zero       = (i_q == '0);
		stat.l_ge_n       = (lidx >= n_q);
		stat.moved        = (big_q != node_q);
		stat.build        = !sort_q;
		stat.n_le_1       = (n_q <= CW'(1));
		stat.out_full     = ovld_q;
		stat.more         = more;
	end

endmodule

`default_nettype wire

FILE: hw/rtl/heap_sort_engine.sv
// Top level of the heap sort engine: microcode sequencer plus datapath.
//
//  channel | dir | handshake           | word
//  --------+-----+---------------------+--------------------------------------
//  in      | in  | in_valid / in_ready | in_word  {value, last}
//  out     | out | out_valid/out_ready | out_word {sorted_value, last_result,
//          |     |                     |           overflow}
//
// Loading: one cycle per word; words past 64 are dropped and flagged. The last word
// starts the sort, bound by one store read per cycle: each sift level reads the left
// child, reads the right child, compares and moves the hole.
// Each result waits until the last one is taken; out_ready low holds the sequencer.
// Reset clears counters and flags only; the store needs no clearing pass.
`default_nettype none

module heap_sort_engine (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire hse_pkg::hse_in_t in_word,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output hse_pkg::hse_out_t     out_word
);
	import hse_pkg::*;

	hse_ctrl_t ctrl;  // control word of the current microstep
	hse_stat_t stat;  // branch flags back from the datapath

	// step counter and control store
	hse_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// store, sift registers, compare and output register
	hse_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.stat      (stat),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/hse_checker.sv
// Port-level checks of the heap sort engine and their bind.
`default_nettype none

module hse_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire hse_pkg::hse_in_t  in_word,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire hse_pkg::hse_out_t out_word
);
	import hse_pkg::*;

	// a stalled result stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out word dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_word))
		else $error("out word changed while stalled");

	// the word marked last closes the input side while sorting
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_word.last |=> !in_ready)
		else $error("input still open after last word");

	// results are produced only while input is closed
	a_out_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_ready)
		else $error("result issued during load");

endmodule

bind heap_sort_engine hse_checker u_hse_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_word   (in_word),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_word  (out_word)
);

`default_nettype wire

FILE: tb/sv/heap_sort_engine_check.sv
// Checker for the heap sort engine: predicts every sorted word and compares it on the out channel.
module heap_sort_engine_check
	import hse_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     in_ready,
	input  wire hse_in_t  in_word,
	input  wire logic     out_valid,
	input  wire logic     out_ready,
	input  wire hse_out_t out_word,
	output int            fails,
	output int            pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// shadow of the element store and its bookkeeping
	logic signed [DW-1:0] held [MAX_ITEMS];
	int unsigned          held_count;
	bit                   held_dropped;
	hse_out_t             sorted_due[$];
	int                   miss_total;

	function automatic void swap_held(int unsigned a, int unsigned b);
		logic signed [DW-1:0] t;
		t       = held[a];
		held[a] = held[b];
		held[b] = t;
	endfunction

	function automatic void sift_held(int unsigned n, int unsigned root);
		int unsigned node, big, l, r;
		bit          settled;
		node    = root;
		settled = 1'b0;
		while (!settled) begin
			big = node;
			l   = 2 * node + 1;
			r   = 2 * node + 2;
			if (l < n && held[l] > held[big])
				big = l;
			if (r < n && held[r] > held[big])
				big = r;
			if (big == node) begin
				settled = 1'b1;
			end else begin
				swap_held(node, big);
				node = big;
			end
		end
	endfunction

	// heapsort of the first n held values, ascending
	function automatic void sort_held(int unsigned n);
		for (int unsigned i = n / 2; i > 0; i--)
			sift_held(n, i - 1);
		for (int unsigned i = n; i > 1; i--) begin
			swap_held(0, i - 1);
			sift_held(i - 1, 0);
		end
	endfunction

	function automatic void absorb_word(hse_in_t w);
		hse_out_t r;
		if (held_count < MAX_ITEMS) begin
			held[held_count] = w.value;
			held_count++;
		end else begin
			held_dropped = 1'b1;
		end
		if (w.last) begin
			sort_held(held_count);
			for (int unsigned k = 0; k < held_count; k++) begin
				r.sorted_value = held[k];
				r.last_result  = (k + 1 == held_count);
				r.overflow     = held_dropped;
				sorted_due.push_back(r);
			end
			held_count   = 0;
			held_dropped = 1'b0;
		end
	endfunction

	function automatic void check_word(hse_out_t got);
		hse_out_t want;
		if (sorted_due.size() == 0) begin
			miss_total++;
			if (miss_total <= 10)
				$display("unexpected word: sorted_value %0d last_result %0b overflow %0b",
					got.sorted_value, got.last_result, got.overflow);
		end else begin
			want = sorted_due.pop_front();
			if (got !== want) begin
				miss_total++;
				if (miss_total <= 10)
					$display("mismatch: sorted_value exp %0d got %0d, last_result exp %0b got %0b, overflow exp %0b got %0b",
						want.sorted_value, got.sorted_value, want.last_result,
						got.last_result, want.overflow, got.overflow);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sorted_due.delete();
			held_count   = 0;
			held_dropped = 1'b0;
			miss_total   = 0;
			fails   <= 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready)
				check_word(out_word);
			if (in_valid && in_ready)
				absorb_word(in_word);
			fails   <= miss_total;
			pending <= sorted_due.size();
		end
	end

endmodule

FILE: tb/sv/heap_sort_engine_test.sv
// Testbench top of the heap sort engine: clock, reset, word traffic on both channels, verdict.
module heap_sort_engine_test
	import hse_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 40000; // quiet cycles
	localparam int MAX_GAP        = 12;
	localparam int TAIL_CYCLES    = 64;
	localparam int WORD_TARGET    = 250;

	localparam logic signed [DW-1:0] VAL_MAX = 32'sh7fffffff;
	localparam logic signed [DW-1:0] VAL_MIN = 32'sh80000000;

	// how the values of a random set are drawn
	typedef enum int {MIX_WIDE, MIX_NARROW, MIX_EXTREME} mix_t;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     in_valid  = 1'b0;
	logic     in_ready;
	hse_in_t  in_word   = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	hse_out_t out_word;

	int          fails;
	int          pending;
	int unsigned words_sent   = 0;
	bit          sender_gaps  = 1'b1;
	bit          receiver_gaps = 1'b1;

	heap_sort_engine u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	heap_sort_engine_check u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.fails     (fails),
		.pending   (pending)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Offer one word on the in channel. A random idle gap comes first (valid low),
	// then valid stays high with the word held until the handshake. On return
	// valid is still high; the caller must lower it or replace the word in the
	// same time step, which every caller below does.
	task automatic send_word(input logic signed [DW-1:0] v, input logic is_last);
		hse_in_t     w;
		int unsigned gap;
		w.value = v;
		w.last  = is_last;
		gap = sender_gaps ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (!in_ready);
		words_sent++;
	endtask

	function automatic logic signed [DW-1:0] pick_value(mix_t mix);
		case (mix)
			MIX_WIDE:   return $urandom;
			// tight range: plenty of duplicates and sign changes
			MIX_NARROW: return int'($urandom_range(0, 8)) - 4;
			default: begin
				case ($urandom_range(0, 3))
					0:       return VAL_MAX;
					1:       return VAL_MIN;
					2:       return 0;
					default: return -1;
				endcase
			end
		endcase
	endfunction

	// one well-formed set: size words, the final one flagged last
	task automatic send_set(input int unsigned size, input mix_t mix);
		for (int unsigned k = 0; k < size; k++)
			send_word(pick_value(mix), k + 1 == size);
	endtask

	// hold the sender off until every predicted word has come out
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Receiver: a random stall before each word, sometimes long stretches
	// with no stall at all.
	initial begin
		int unsigned stall;
		int unsigned taken;
		taken = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (taken % 40 == 0)
				receiver_gaps = ($urandom_range(0, 3) != 0);
			stall = receiver_gaps ? $urandom_range(0, MAX_GAP) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	// Watchdog: too many cycles with no handshake on either channel means a hang.
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int unsigned size;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single-word sets at both extremes
		send_word(VAL_MAX, 1'b1);
		send_word(VAL_MIN, 1'b1);
		// extremes mixed with zero and +-1, duplicated
		send_word(0, 1'b0);
		send_word(-1, 1'b0);
		send_word(1, 1'b0);
		send_word(VAL_MAX, 1'b0);
		send_word(VAL_MIN, 1'b0);
		send_word(VAL_MAX, 1'b0);
		send_word(VAL_MIN, 1'b0);
		send_word(0, 1'b1);
		// equal pair, then all-equal negatives
		send_word(5, 1'b0);
		send_word(5, 1'b1);
		send_word(-7, 1'b0);
		send_word(-7, 1'b0);
		send_word(-7, 1'b1);
		// strictly descending input
		for (int k = 9; k >= 4; k--)
			send_word(k, k == 4);
		drain_results();

		// store exactly full, then overflow where the last word itself is dropped
		send_set(MAX_ITEMS, MIX_WIDE);
		send_set(MAX_ITEMS + 2, MIX_WIDE);
		drain_results();

		// random sets, mostly small; now and then a large one
		while (words_sent < WORD_TARGET) begin
			sender_gaps = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 7) == 0)
				size = $urandom_range(13, MAX_ITEMS + 3);
			else
				size = $urandom_range(1, 12);
			send_set(size, mix_t'($urandom_range(0, 2)));
			if ($urandom_range(0, 4) == 0)
				drain_results();
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/hse_pkg.sv
hw/rtl/hse_sequencer.sv
hw/rtl/hse_datapath.sv
hw/rtl/heap_sort_engine.sv
hw/rtl/hse_checker.sv
tb/sv/heap_sort_engine_check.sv
tb/sv/heap_sort_engine_test.sv
